>>> design/uncovered_code_run_scanner_top_macros.svh
// Assertion macros shared by the scanner's checker.
`ifndef UNCOVERED_CODE_RUN_SCANNER_TOP_MACROS_SVH
`define UNCOVERED_CODE_RUN_SCANNER_TOP_MACROS_SVH

// Checked only while out of reset.
`define UCRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define UCRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/ucrs_pkg.sv
// Shared types and constants of the uncovered code run scanner.
package ucrs_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_BYTE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    K_START  = 2'd0,
    K_APPEND = 2'd1,
    K_BYTE   = 2'd2
  } kind_e;

  localparam int unsigned MAX_RANGES_DEF = 64;
  localparam int unsigned Q_DEPTH        = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIND = 1'b1;

  localparam logic [31:0] MIN_RUN_RST  = 32'd16;
  localparam logic [15:0] MAX_FIND_RST = 16'd64;

  localparam logic [7:0] PAD_ZERO = 8'h00;
  localparam logic [7:0] PAD_INT3 = 8'hCC;

  // One classified request as it waits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [63:0] tag;
    logic [31:0] w0;    // section address on start, range begin on append
    logic [31:0] w1;    // range end on append
    logic        cand;  // valid byte that is not padding
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] min_run;
    logic [15:0] max_findings;
  } cfg_t;

endpackage

>>> design/ucrs_req_if.sv
// Request channel of the scanner: valid, ready and the request fields.
interface ucrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] module_tag;
  logic [31:0] section_rva;
  logic [31:0] range_begin;
  logic [31:0] range_end;
  logic [7:0]  code_byte;
  logic        byte_valid;
  logic        last_byte;

  modport source (output valid, op, module_tag, section_rva, range_begin, range_end,
                  code_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, op, module_tag, section_rva, range_begin, range_end,
                  code_byte, byte_valid, last_byte, output ready);
endinterface

>>> design/ucrs_find_if.sv
// Finding channel of the scanner: valid, ready and the finding fields.
interface ucrs_find_if;
  logic        valid;
  logic        ready;
  logic [63:0] finding_module;
  logic [31:0] finding_rva;
  logic [31:0] finding_length;
  logic        limit_reached;

  modport source (output valid, finding_module, finding_rva, finding_length,
                  limit_reached, input ready);
  modport sink   (input valid, finding_module, finding_rva, finding_length,
                  limit_reached, output ready);
endinterface

>>> design/ucrs_front.sv
// Front end: takes requests, classifies them and pushes them into the queue.
module ucrs_front (
  ucrs_req_if.sink            req_i,
  output logic                push_valid_o,
  output ucrs_pkg::item_t     push_item_o,
  input  logic                push_ready_i
);
  import ucrs_pkg::*;

  logic known_op;

  always_comb begin
    known_op         = 1'b1;
    push_item_o.kind = K_BYTE;
    push_item_o.w0   = req_i.range_begin;
    case (op_e'(req_i.op))
      OP_START: begin
        push_item_o.kind = K_START;
        push_item_o.w0   = req_i.section_rva;
      end
      OP_APPEND: push_item_o.kind = K_APPEND;
      OP_BYTE:   push_item_o.kind = K_BYTE;
      default:   known_op = 1'b0;
    endcase
    push_item_o.tag  = req_i.module_tag;
    push_item_o.w1   = req_i.range_end;
    push_item_o.cand = req_i.byte_valid && (req_i.code_byte != PAD_ZERO) &&
                       (req_i.code_byte != PAD_INT3);
    push_item_o.last = req_i.last_byte;
  end

  // Unknown opcodes are taken and dropped here.
  assign push_valid_o = req_i.valid && known_op;
  assign req_i.ready  = push_ready_i;

endmodule

>>> design/ucrs_queue.sv
// Short queue of classified requests between the front end and the back end.
module ucrs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ucrs_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ucrs_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);
  import ucrs_pkg::*;

  localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

  item_t           slot_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/ucrs_back.sv
// Back end: range table, coverage scan, run tracking and the finding register.
module ucrs_back #(
  parameter int unsigned MAX_RANGES = ucrs_pkg::MAX_RANGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ucrs_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  input  ucrs_pkg::item_t  pop_item_i,
  output logic             pop_ready_o,
  ucrs_find_if.source      find_o
);
  import ucrs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);
  localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] rng_cnt_q, rng_cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [31:0]     base_q, base_d;
  logic [63:0]     module_q, module_d;
  logic [31:0]     offset_q, offset_d;
  logic            run_open_q, run_open_d;
  logic [31:0]     run_start_q, run_start_d;
  logic [15:0]     find_cnt_q, find_cnt_d;
  logic [31:0]     addr_q, addr_d;
  logic            last_q, last_d;
  logic            suspect_q, suspect_d;

  logic [31:0]     beg_mem [MAX_RANGES];
  logic [31:0]     end_mem [MAX_RANGES];
  logic [31:0]     rd_beg_q, rd_end_q;
  logic            mem_we, rd_en;

  logic            out_valid_q, out_valid_d;
  logic [63:0]     out_module_q;
  logic [31:0]     out_rva_q, out_len_q;
  logic            out_limit_q;
  logic            out_load;

  logic            limit_hit, hit, scan_done, closing, emit, out_free;
  logic [31:0]     end_off, start_off, run_len;
  logic [15:0]     cnt_inc;

  assign limit_hit = (find_cnt_q >= cfg_i.max_findings);
  // Read data of the previous cycle's table read is valid once one read went out.
  assign hit       = (idx_q != '0) && (addr_q >= rd_beg_q) && (addr_q < rd_end_q);
  assign scan_done = (idx_q == rng_cnt_q);

  assign end_off   = suspect_q ? offset_q + 32'd1 : offset_q;
  assign start_off = (suspect_q && !run_open_q) ? offset_q : run_start_q;
  assign run_len   = end_off - start_off;
  assign closing   = suspect_q ? last_q : run_open_q;
  assign emit      = closing && (run_len >= cfg_i.min_run);
  assign cnt_inc   = find_cnt_q + 16'd1;
  assign out_free  = !out_valid_q || find_o.ready;

  always_comb begin
    state_d     = state_q;
    rng_cnt_d   = rng_cnt_q;
    idx_d       = idx_q;
    base_d      = base_q;
    module_d    = module_q;
    offset_d    = offset_q;
    run_open_d  = run_open_q;
    run_start_d = run_start_q;
    find_cnt_d  = find_cnt_q;
    addr_d      = addr_q;
    last_d      = last_q;
    suspect_d   = suspect_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    out_valid_d = find_o.ready ? 1'b0 : out_valid_q;

    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          case (pop_item_i.kind)
            K_START: begin
              module_d    = pop_item_i.tag;
              base_d      = pop_item_i.w0;
              rng_cnt_d   = '0;
              offset_d    = '0;
              run_open_d  = 1'b0;
              run_start_d = '0;
            end
            K_APPEND: begin
              if (rng_cnt_q < CntW'(MAX_RANGES)) begin
                mem_we    = 1'b1;
                rng_cnt_d = rng_cnt_q + 1'b1;
              end
            end
            K_BYTE: begin
              if (!limit_hit) begin
                addr_d = base_q + offset_q;
                last_d = pop_item_i.last;
                idx_d  = '0;
                if (!pop_item_i.cand) begin
                  suspect_d = 1'b0;
                  state_d   = ST_RESOLVE;
                end else if (rng_cnt_q == '0) begin
                  suspect_d = 1'b1;
                  state_d   = ST_RESOLVE;
                end else begin
                  state_d = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          suspect_d = 1'b0;
          state_d   = ST_RESOLVE;
        end else if (scan_done) begin
          suspect_d = 1'b1;
          state_d   = ST_RESOLVE;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESOLVE: begin
        if (!emit || out_free) begin
          offset_d = offset_q + 32'd1;
          if (suspect_q && !last_q) begin
            run_open_d  = 1'b1;
            run_start_d = start_off;
          end else if (closing) begin
            run_open_d = 1'b0;
          end
          if (emit) begin
            find_cnt_d  = cnt_inc;
            out_valid_d = 1'b1;
            out_load    = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rng_cnt_q   <= '0;
      idx_q       <= '0;
      base_q      <= '0;
      module_q    <= '0;
      offset_q    <= '0;
      run_open_q  <= 1'b0;
      run_start_q <= '0;
      find_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rng_cnt_q   <= rng_cnt_d;
      idx_q       <= idx_d;
      base_q      <= base_d;
      module_q    <= module_d;
      offset_q    <= offset_d;
      run_open_q  <= run_open_d;
      run_start_q <= run_start_d;
      find_cnt_q  <= find_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    last_q    <= last_d;
    suspect_q <= suspect_d;
    if (out_load) begin
      out_module_q <= module_q;
      out_rva_q    <= base_q + start_off;
      out_len_q    <= run_len;
      out_limit_q  <= (cnt_inc >= cfg_i.max_findings);
    end
  end

  // Range table, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      beg_mem[rng_cnt_q[IdxW-1:0]] <= pop_item_i.w0;
      end_mem[rng_cnt_q[IdxW-1:0]] <= pop_item_i.w1;
    end
    if (rd_en) begin
      rd_beg_q <= beg_mem[idx_q[IdxW-1:0]];
      rd_end_q <= end_mem[idx_q[IdxW-1:0]];
    end
  end

  assign find_o.valid          = out_valid_q;
  assign find_o.finding_module = out_module_q;
  assign find_o.finding_rva    = out_rva_q;
  assign find_o.finding_length = out_len_q;
  assign find_o.limit_reached  = out_limit_q;

endmodule

>>> design/uncovered_code_run_scanner_top.sv
// Top level of the uncovered code run scanner.
//
// The request channel carries three kinds of request: start a module (latches
// the module tag and section address, empties the range table and closes any
// open run), append a function range, and one code byte of the section.
// Unknown opcodes are taken and dropped. The finding channel returns at most
// one finding per code byte, registered, so it holds while the receiver stalls.
// A start or append request is handled in the back end's idle state. A code byte
// that is padding, invalid, or meets an empty table goes straight to the resolve
// state; otherwise the back end walks the range table through its single read
// port, one range per cycle, and stops early when a covering range is found.
// A two-entry request queue lets the front end keep taking requests while the
// back end scans or waits on a stalled finding.
// Configuration (min_run, max_findings) is written through the plain write port;
// the user must write it only while the block is idle; the block does not enforce
// this. Reset empties the queue and the range table, clears run state and the
// finding count, and loads the default configuration.
module uncovered_code_run_scanner_top #(
  parameter int unsigned MAX_RANGES = ucrs_pkg::MAX_RANGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ucrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ucrs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ucrs_req_if.sink                        req_i,
  ucrs_find_if.source                     find_o
);
  import ucrs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_RUN:  cfg_d.min_run      = cfg_wdata_i[31:0];
        CFG_MAX_FIND: cfg_d.max_findings = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_run      <= MIN_RUN_RST;
      cfg_q.max_findings <= MAX_FIND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each request as it is taken.
  ucrs_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  ucrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // The back end owns the range table and produces findings.
  ucrs_back #(
    .MAX_RANGES (MAX_RANGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .find_o      (find_o)
  );

endmodule

>>> design/ucrs_checker.sv
// Port-level checker of the scanner and its bind to the top level.
`include "uncovered_code_run_scanner_top_macros.svh"

module ucrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        find_valid_i,
  input logic        find_ready_i,
  input logic [63:0] find_module_i,
  input logic [31:0] find_rva_i,
  input logic [31:0] find_len_i,
  input logic        find_limit_i
);

  logic         find_stall;
  logic         req_take;
  logic [128:0] find_bits;

  assign find_stall = find_valid_i && !find_ready_i;
  assign req_take   = req_valid_i && req_ready_i;
  assign find_bits  = {find_module_i, find_rva_i, find_len_i, find_limit_i};

  // A stalled finding keeps its valid and its fields.
  `UCRS_ASSERT(a_find_hold, find_stall |=> find_valid_i && $stable(find_bits), "stalled finding changed")

  // The queue fills only through a request taken in the cycle before.
  `UCRS_ASSERT(a_ready_fall, $fell(req_ready_i) |-> $past(req_take), "ready fell with no request taken")

  // No finding is offered while reset is held.
  `UCRS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !find_valid_i, "finding valid during reset")

endmodule

bind uncovered_code_run_scanner_top ucrs_checker u_ucrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .find_valid_i  (find_o.valid),
  .find_ready_i  (find_o.ready),
  .find_module_i (find_o.finding_module),
  .find_rva_i    (find_o.finding_rva),
  .find_len_i    (find_o.finding_length),
  .find_limit_i  (find_o.limit_reached)
);
